### rtl/wvt_pkg.sv
// Shared widths, constants and types for the wall view transform pipeline.
`default_nettype none

package wvt_pkg;

  localparam int CoordW   = 16;            // world coordinates and heights
  localparam int PitchW   = 8;
  localparam int DxW      = CoordW + 1;    // coordinate minus viewer position
  localparam int ProdW    = DxW + CoordW;  // rotation products
  localparam int TrW      = ProdW - 14;    // rotation product after Q14 truncation
  localparam int SxW      = 20;            // side and depth
  localparam int BaseW    = DxW + 5;       // 32 * (floor - eye height)
  localparam int PpW      = 28;            // pitch term plus base
  localparam int ValW     = 24;            // side, lower and upper values
  localparam int DenW     = 21;            // depth difference and divisor
  localparam int DiffW    = 25;            // other end value minus own value
  localparam int ClipPW   = 45;            // clip products
  localparam int FocW     = 9;
  localparam int FocPW    = ValW + FocW;   // value times focal length
  localparam int NumW     = 44;            // divider numerator and quotient
  localparam int ScaleW   = NumW + FocW;   // quotient times focal length
  localparam int OutW     = 32;
  localparam int Lanes    = 6;
  localparam int CfgIdxW  = 3;

  localparam int Q14Bias    = (1 << 14) - 1;
  localparam int PitchBias  = 31;
  localparam int NearDepth  = 1;
  localparam int CosReset   = 16384;
  localparam logic signed [FocW-1:0] Focal = 9'sd200;

  localparam int DefScreenWidth  = 640;
  localparam int DefScreenHeight = 480;

  typedef enum logic [CfgIdxW-1:0] {
    CfgViewerX  = 3'd0,
    CfgViewerY  = 3'd1,
    CfgViewerZ  = 3'd2,
    CfgCos      = 3'd3,
    CfgSin      = 3'd4,
    CfgPitch    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] vx;
    logic signed [CoordW-1:0] vy;
    logic signed [CoordW-1:0] vz;
    logic signed [CoordW-1:0] cos_v;
    logic signed [CoordW-1:0] sin_v;
    logic signed [PitchW-1:0] pitch;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/wall_view_transform_project.sv
// Top level: wall view transform, near clip and perspective projection.
//
//  Channel   Dir  Handshake              Payload
//  s_axis    in   tvalid/tready          tdata 96b walls, tuser swap_ends
//  m_axis    out  tvalid/tready          tdata 192b screen values, tuser visible
//  cfg       in   cfg_we_i (no wait)     cfg_idx_i, cfg_wdata_i
//
// One wall per clock is accepted while the pipeline advances; the path has six transform
// stages, three clip stages, the 46-stage divider (one quotient bit per stage over a
// 44-bit numerator) and two stages of scaling and saturation.
// The whole pipeline advances together; it holds only while the output
// register is full and not taken, so a transaction is never lost or repeated.
// Reset clears valid bits and restores the configuration registers.
`default_nettype none

module wall_view_transform_project import wvt_pkg::*; #(
  parameter int SCREEN_WIDTH  = DefScreenWidth,
  parameter int SCREEN_HEIGHT = DefScreenHeight
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // end_a_x, end_a_y, end_b_x, end_b_y, floor_height, wall_height (16b each)
  input  logic [6*CoordW-1:0]   s_axis_tdata,
  // swap_ends
  input  logic [0:0]            s_axis_tuser,
  // master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // screen_x_a, screen_x_b, lower_y_a, lower_y_b, upper_y_a, upper_y_b (32b each)
  output logic [Lanes*OutW-1:0] m_axis_tdata,
  // visible
  output logic [0:0]            m_axis_tuser,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CoordW-1:0]     cfg_wdata_i
);

  localparam int SumW = ScaleW + 1;
  localparam logic signed [SumW-1:0] HalfW  = SumW'(SCREEN_WIDTH / 2);
  localparam logic signed [SumW-1:0] HalfH  = SumW'(SCREEN_HEIGHT / 2);
  localparam logic signed [SumW-1:0] SatHi  = SumW'(2147483647);
  localparam logic signed [SumW-1:0] SatLo  = -SatHi - SumW'(1);

  cfg_t cfg_q;
  logic adv;

  // single stall enable for every stage
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vx    <= '0;
      cfg_q.vy    <= '0;
      cfg_q.vz    <= '0;
      cfg_q.cos_v <= CoordW'(CosReset);
      cfg_q.sin_v <= '0;
      cfg_q.pitch <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgViewerX: cfg_q.vx    <= cfg_wdata_i;
        CfgViewerY: cfg_q.vy    <= cfg_wdata_i;
        CfgViewerZ: cfg_q.vz    <= cfg_wdata_i;
        CfgCos:     cfg_q.cos_v <= cfg_wdata_i;
        CfgSin:     cfg_q.sin_v <= cfg_wdata_i;
        CfgPitch:   cfg_q.pitch <= cfg_wdata_i[PitchW-1:0];
        default: ;
      endcase
    end
  end

  // viewer-space transform
  logic                   fr_v;
  logic signed [SxW-1:0]  fr_sx [2], fr_dp [2];
  logic signed [ValW-1:0] fr_lo [2], fr_up [2];

  wvt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s_axis_tvalid),
    .a_x_i   ($signed(s_axis_tdata[0*CoordW +: CoordW])),
    .a_y_i   ($signed(s_axis_tdata[1*CoordW +: CoordW])),
    .b_x_i   ($signed(s_axis_tdata[2*CoordW +: CoordW])),
    .b_y_i   ($signed(s_axis_tdata[3*CoordW +: CoordW])),
    .floor_i ($signed(s_axis_tdata[4*CoordW +: CoordW])),
    .wall_i  ($signed(s_axis_tdata[5*CoordW +: CoordW])),
    .swap_i  (s_axis_tuser[0]),
    .cfg_i   (cfg_q),
    .valid_o (fr_v),
    .sx_o    (fr_sx),
    .dp_o    (fr_dp),
    .lo_o    (fr_lo),
    .up_o    (fr_up)
  );

  // near test and divide set-up
  logic                   cl_v, cl_vis;
  logic signed [NumW-1:0] cl_num [Lanes];
  logic signed [DenW-1:0] cl_den [Lanes];
  logic                   cl_mul [Lanes];

  wvt_clip u_clip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fr_v),
    .sx_i    (fr_sx),
    .dp_i    (fr_dp),
    .lo_i    (fr_lo),
    .up_i    (fr_up),
    .valid_o (cl_v),
    .vis_o   (cl_vis),
    .num_o   (cl_num),
    .den_o   (cl_den),
    .mul_o   (cl_mul)
  );

  // one divider lane per output value; tag carries {visible, scale-after}
  logic [Lanes-1:0]       dv_v;
  logic signed [NumW-1:0] dv_q [Lanes];
  logic [1:0]             dv_tag [Lanes];

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    wvt_div #(
      .NW (NumW),
      .DW (DenW),
      .TW (2)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (cl_v),
      .num_i   (cl_num[l]),
      .den_i   (cl_den[l]),
      .tag_i   ({cl_vis, cl_mul[l]}),
      .valid_o (dv_v[l]),
      .quo_o   (dv_q[l]),
      .tag_o   (dv_tag[l])
    );
  end

  // scale clipped ends by the focal length
  logic                     sc_v_q, sc_vis_q;
  logic signed [ScaleW-1:0] sc_q [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_v_q        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      sc_v_q        <= &dv_v;
      m_axis_tvalid <= sc_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_vis_q <= dv_tag[0][1];
      for (int l = 0; l < Lanes; l++) begin
        sc_q[l] <= dv_tag[l][0] ? dv_q[l] * Focal : ScaleW'(dv_q[l]);
      end
    end
  end

  // add screen centre, saturate, zero an invisible wall
  logic signed [SumW-1:0] sum [Lanes];
  logic [OutW-1:0]        res [Lanes];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      sum[l] = SumW'(sc_q[l]) + ((l < 2) ? HalfW : HalfH);
      if (!sc_vis_q) begin
        res[l] = '0;
      end else if (sum[l] > SatHi) begin
        res[l] = SatHi[OutW-1:0];
      end else if (sum[l] < SatLo) begin
        res[l] = SatLo[OutW-1:0];
      end else begin
        res[l] = sum[l][OutW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tuser[0] <= sc_vis_q;
      for (int l = 0; l < Lanes; l++) begin
        m_axis_tdata[l*OutW +: OutW] <= res[l];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/wvt_front.sv
// Viewer-space transform: translate, rotate by heading, add pitch to heights.
`default_nettype none

module wvt_front import wvt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     valid_i,
  input  logic signed [CoordW-1:0] a_x_i,
  input  logic signed [CoordW-1:0] a_y_i,
  input  logic signed [CoordW-1:0] b_x_i,
  input  logic signed [CoordW-1:0] b_y_i,
  input  logic signed [CoordW-1:0] floor_i,
  input  logic signed [CoordW-1:0] wall_i,
  input  logic                     swap_i,
  input  cfg_t                     cfg_i,
  output logic                     valid_o,
  output logic signed [SxW-1:0]    sx_o [2],
  output logic signed [SxW-1:0]    dp_o [2],
  output logic signed [ValW-1:0]   lo_o [2],
  output logic signed [ValW-1:0]   up_o [2]
);

  // truncate toward zero after dividing by 2^14
  function automatic logic signed [TrW-1:0] trunc_q14(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] b;
    b = p + (p[ProdW-1] ? ProdW'(Q14Bias) : ProdW'(0));
    return b[ProdW-1:14];
  endfunction

  function automatic logic signed [ValW-1:0] trunc_p32(input logic signed [PpW-1:0] s);
    logic signed [PpW-1:0] b;
    b = s + (s[PpW-1] ? PpW'(PitchBias) : PpW'(0));
    return ValW'($signed(b[PpW-1:5]));
  endfunction

  logic [5:0] v_q;

  logic signed [DxW-1:0]    dx0_q [2], dy0_q [2];
  logic signed [DxW-1:0]    fz0_q;
  logic signed [CoordW-1:0] wh0_q, wh1_q, wh2_q, wh3_q, wh4_q;
  logic signed [ProdW-1:0]  pxc1_q [2], pys1_q [2], pyc1_q [2], pxs1_q [2];
  logic signed [DxW-1:0]    fz1_q;
  logic signed [SxW-1:0]    sx2_q [2], dp2_q [2], sx3_q [2], dp3_q [2];
  logic signed [SxW-1:0]    sx4_q [2], dp4_q [2], sx5_q [2], dp5_q [2];
  logic signed [BaseW-1:0]  base2_q, base3_q;
  logic signed [PpW-1:0]    pp3_q [2];
  logic signed [ValW-1:0]   lo4_q [2], lo5_q [2], up5_q [2];

  logic signed [CoordW-1:0] px [2], py [2];

  always_comb begin
    px[0] = swap_i ? b_x_i : a_x_i;
    py[0] = swap_i ? b_y_i : a_y_i;
    px[1] = swap_i ? a_x_i : b_x_i;
    py[1] = swap_i ? a_y_i : b_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 2; k++) begin
        // translate
        dx0_q[k]  <= DxW'(px[k]) - DxW'(cfg_i.vx);
        dy0_q[k]  <= DxW'(py[k]) - DxW'(cfg_i.vy);
        // rotate
        pxc1_q[k] <= dx0_q[k] * cfg_i.cos_v;
        pys1_q[k] <= dy0_q[k] * cfg_i.sin_v;
        pyc1_q[k] <= dy0_q[k] * cfg_i.cos_v;
        pxs1_q[k] <= dx0_q[k] * cfg_i.sin_v;
        sx2_q[k]  <= SxW'(trunc_q14(pxc1_q[k])) - SxW'(trunc_q14(pys1_q[k]));
        dp2_q[k]  <= SxW'(trunc_q14(pyc1_q[k])) + SxW'(trunc_q14(pxs1_q[k]));
        // pitch term
        pp3_q[k]  <= dp2_q[k] * cfg_i.pitch;
        sx3_q[k]  <= sx2_q[k];
        dp3_q[k]  <= dp2_q[k];
        lo4_q[k]  <= trunc_p32(pp3_q[k] + PpW'(base3_q));
        sx4_q[k]  <= sx3_q[k];
        dp4_q[k]  <= dp3_q[k];
        lo5_q[k]  <= lo4_q[k];
        up5_q[k]  <= lo4_q[k] + ValW'(wh4_q);
        sx5_q[k]  <= sx4_q[k];
        dp5_q[k]  <= dp4_q[k];
      end
      fz0_q   <= DxW'(floor_i) - DxW'(cfg_i.vz);
      wh0_q   <= wall_i;
      fz1_q   <= fz0_q;
      wh1_q   <= wh0_q;
      base2_q <= $signed({fz1_q, 5'b0});
      wh2_q   <= wh1_q;
      base3_q <= base2_q;
      wh3_q   <= wh2_q;
      wh4_q   <= wh3_q;
    end
  end

  assign valid_o = v_q[5];
  assign sx_o    = sx5_q;
  assign dp_o    = dp5_q;
  assign lo_o    = lo5_q;
  assign up_o    = up5_q;

endmodule

`default_nettype wire

### rtl/wvt_clip.sv
// Near-plane test and clip numerators; sets up one divide per output lane.
`default_nettype none

module wvt_clip import wvt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    valid_i,
  input  logic signed [SxW-1:0]   sx_i [2],
  input  logic signed [SxW-1:0]   dp_i [2],
  input  logic signed [ValW-1:0]  lo_i [2],
  input  logic signed [ValW-1:0]  up_i [2],
  output logic                    valid_o,
  output logic                    vis_o,
  output logic signed [NumW-1:0]  num_o [Lanes],
  output logic signed [DenW-1:0]  den_o [Lanes],
  output logic                    mul_o [Lanes]
);

  logic [2:0] v_q;

  logic signed [ValW-1:0]   val [2][3];
  logic                     beh [2];
  logic signed [DenW-1:0]   dd [2];

  logic                     beh0_q [2], beh1_q [2];
  logic                     vis0_q, vis1_q, vis2_q;
  logic signed [DenW-1:0]   dd0_q [2], dd1_q [2];
  logic signed [SxW-1:0]    dp0_q [2], dp1_q [2];
  logic signed [DiffW-1:0]  df0_q [2][3];
  logic signed [ValW-1:0]   val0_q [2][3];
  logic signed [ClipPW-1:0] m1_q [2][3], m2_q [2][3];
  logic signed [FocPW-1:0]  f_q [2][3];
  logic signed [NumW-1:0]   num_q [Lanes];
  logic signed [DenW-1:0]   den_q [Lanes];
  logic                     mul_q [Lanes];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      val[k][0] = ValW'(sx_i[k]);
      val[k][1] = lo_i[k];
      val[k][2] = up_i[k];
      beh[k]    = dp_i[k] < SxW'(NearDepth);
      dd[k]     = DenW'(dp_i[k]) - DenW'(dp_i[1-k]);
      if (dd[k] == '0) begin
        dd[k] = DenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vis0_q <= !(beh[0] && beh[1]);
      vis1_q <= vis0_q;
      vis2_q <= vis1_q;
      for (int k = 0; k < 2; k++) begin
        beh0_q[k] <= beh[k];
        dd0_q[k]  <= dd[k];
        dp0_q[k]  <= dp_i[k];
        beh1_q[k] <= beh0_q[k];
        dd1_q[k]  <= dd0_q[k];
        dp1_q[k]  <= dp0_q[k];
        for (int j = 0; j < 3; j++) begin
          val0_q[k][j] <= val[k][j];
          df0_q[k][j]  <= DiffW'(val[1-k][j]) - DiffW'(val[k][j]);
          m1_q[k][j]   <= val0_q[k][j] * dd0_q[k];
          m2_q[k][j]   <= dp0_q[k] * df0_q[k][j];
          f_q[k][j]    <= val0_q[k][j] * Focal;
          // clipped end: divide the interpolation by d, scale later;
          // open end: divide the scaled value by its depth
          if (beh1_q[k]) begin
            num_q[2*j+k] <= NumW'(m1_q[k][j]) + NumW'(m2_q[k][j]);
            den_q[2*j+k] <= dd1_q[k];
            mul_q[2*j+k] <= 1'b1;
          end else begin
            num_q[2*j+k] <= NumW'(f_q[k][j]);
            den_q[2*j+k] <= DenW'(dp1_q[k]);
            mul_q[2*j+k] <= 1'b0;
          end
        end
      end
    end
  end

  assign valid_o = v_q[2];
  assign vis_o   = vis2_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign mul_o   = mul_q;

endmodule

`default_nettype wire

### rtl/wvt_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
`default_nettype none

module wvt_div import wvt_pkg::*; #(
  parameter int NW = NumW,
  parameter int DW = DenW,
  parameter int TW = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  input  logic [TW-1:0]        tag_i,
  output logic                 valid_o,
  output logic signed [NW-1:0] quo_o,
  output logic [TW-1:0]        tag_o
);

  localparam int Depth = NW + 2;

  logic [Depth-1:0] v_q;
  logic [NW-1:0]    a_q   [NW+1];
  logic [DW-1:0]    r_q   [NW];
  logic [DW-1:0]    dm_q  [NW+1];
  logic             neg_q [NW+1];
  logic [TW-1:0]    tag_q [NW+1];
  logic [NW-1:0]    quo_q;
  logic [TW-1:0]    tagf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[Depth-2:0], valid_i};
    end
  end

  // magnitudes; the most negative value maps to its correct unsigned size
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_q[0]   <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      dm_q[0]  <= den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      neg_q[0] <= num_i[NW-1] ^ den_i[DW-1];
      tag_q[0] <= tag_i;
      r_q[0]   <= '0;
    end
  end

  for (genvar i = 1; i <= NW; i++) begin : g_stage
    logic [DW:0] t;
    logic        ge;

    assign t  = {r_q[i-1], a_q[i-1][NW-1]};
    assign ge = t >= {1'b0, dm_q[i-1]};

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        a_q[i]   <= {a_q[i-1][NW-2:0], ge};
        dm_q[i]  <= dm_q[i-1];
        neg_q[i] <= neg_q[i-1];
        tag_q[i] <= tag_q[i-1];
      end
    end

    if (i < NW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          r_q[i] <= ge ? DW'(t - {1'b0, dm_q[i-1]}) : DW'(t);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      quo_q  <= neg_q[NW] ? -a_q[NW] : a_q[NW];
      tagf_q <= tag_q[NW];
    end
  end

  assign valid_o = v_q[Depth-1];
  assign quo_o   = $signed(quo_q);
  assign tag_o   = tagf_q;

endmodule

`default_nettype wire
